>>> hdl/shbe_pkg.sv
package shbe_pkg;

    localparam int MAX_DEGREE_DEF = 9;
    localparam int N_TERMS        = 55;
    localparam int N_COEF         = 10;
    localparam int DIR_W          = 16;
    localparam int DEG_W          = 4;
    localparam int ORDER_W        = 5;
    localparam int VALUE_W        = 16;
    localparam int IDX_W          = 6;
    localparam int AS_W           = 35;
    localparam int UNIT_Q14       = 16384;
    localparam int ROOT_FRAC      = 22;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [DEG_W-1:0]        degree;
    } t_req;

    typedef struct packed {
        logic signed [ORDER_W-1:0] order;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_PW_RX,
        ST_PW_IY,
        ST_PW_RY,
        ST_PW_IX,
        ST_PH,
        ST_SC,
        ST_SZ,
        ST_PR,
        ST_V,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LL,
        PH_LH,
        PH_HL
    } t_mul_ph;

    typedef int t_coef_row [N_COEF];
    typedef logic signed [AS_W-1:0] t_as_tab [N_TERMS];

    localparam int T_BASE [10] = '{0, 1, 3, 6, 10, 15, 21, 28, 36, 45};

    localparam int T_SG [N_TERMS] = '{
         1, 1,-1, 1,-1, 1, 1,-1, 1,-1,
         1,-1, 1,-1, 1, 1,-1, 1,-1, 1,
        -1, 1,-1, 1,-1, 1,-1, 1, 1,-1,
         1,-1, 1,-1, 1,-1, 1,-1, 1,-1,
         1,-1, 1,-1, 1, 1,-1, 1,-1, 1,
        -1, 1,-1, 1,-1};

    localparam int T_A [N_TERMS] = '{
        1,1,1,1,1,1,1,1,1,1,
        3,3,3,3,3,1,1,1,1,3,
        3,1,1,1,1,3,3,1,1,1,
        3,3,3,3,3,3,1,3,3,1,
        3,3,1,3,3,1,3,3,1,3,
        3,1,3,3,1};

    localparam int T_SH [N_TERMS] = '{
        1,1,1,2,1,2,2,3,2,3,
        4,3,3,3,4,4,4,3,5,4,
        5,5,4,6,5,5,5,6,5,6,
        6,6,5,6,6,7,8,6,7,6,
        7,6,7,6,8,8,8,7,8,8,
        8,7,9,9,9};

    localparam int T_C [N_TERMS] = '{
        1, 3, 3, 5, 15, 15, 7, 21, 105, 35,
        1, 5, 5, 35, 35, 11, 165, 1155, 385, 385,
        77, 13, 273, 1365, 1365, 91, 1001, 3003, 15, 105,
        35, 35, 385, 385, 5005, 1430, 17, 17, 595, 19635,
        1309, 17017, 7293, 12155, 12155, 19, 95, 1045, 21945, 190190,
        2717, 40755, 13585, 461890, 230945};

    localparam int T_D [N_TERMS] = '{
        1,1,2,1,2,2,1,1,2,1,
        1,1,2,1,2,1,2,2,1,2,
        1,1,2,1,1,2,1,1,1,2,
        1,2,2,2,1,1,1,2,1,2,
        2,2,1,2,2,1,2,1,1,1,
        1,1,1,1,1};

    localparam int T_SC [N_TERMS] = '{
        0,0,0,-1,0,0,-3,-1,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0};

    localparam int T_SZ [N_TERMS] = '{
        0,0,0,0,0,0,1,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0};

    localparam t_coef_row T_P [N_TERMS] = '{
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,0,2,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,0,0,2,0,0,0,0,0,0},
        '{0,0,4,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{3,0,-30,0,35,0,0,0,0,0},
        '{0,-3,0,7,0,0,0,0,0,0},
        '{-1,0,7,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,15,0,-70,0,63,0,0,0,0},
        '{1,0,-14,0,21,0,0,0,0,0},
        '{0,-1,0,3,0,0,0,0,0,0},
        '{-1,0,9,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{-5,0,105,0,-315,0,231,0,0,0},
        '{0,5,0,-30,0,33,0,0,0,0},
        '{1,0,-18,0,33,0,0,0,0,0},
        '{0,-3,0,11,0,0,0,0,0,0},
        '{-1,0,11,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,-35,0,315,0,-693,0,429,0,0},
        '{-5,0,135,0,-495,0,429,0,0,0},
        '{0,15,0,-110,0,143,0,0,0,0},
        '{3,0,-66,0,143,0,0,0,0,0},
        '{0,-3,0,13,0,0,0,0,0,0},
        '{-1,0,13,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{35,0,-1260,0,6930,0,-12012,0,6435,0},
        '{0,-35,0,385,0,-1001,0,715,0,0},
        '{-1,0,33,0,-143,0,143,0,0,0},
        '{0,3,0,-26,0,39,0,0,0,0},
        '{1,0,-26,0,65,0,0,0,0,0},
        '{0,-1,0,5,0,0,0,0,0,0},
        '{-1,0,15,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0},
        '{0,315,0,-4620,0,18018,0,-25740,0,12155},
        '{7,0,-308,0,2002,0,-4004,0,2431,0},
        '{0,-7,0,91,0,-273,0,221,0,0},
        '{-1,0,39,0,-195,0,221,0,0,0},
        '{0,1,0,-10,0,17,0,0,0,0},
        '{1,0,-30,0,85,0,0,0,0,0},
        '{0,-3,0,17,0,0,0,0,0,0},
        '{-1,0,17,0,0,0,0,0,0,0},
        '{0,1,0,0,0,0,0,0,0,0},
        '{1,0,0,0,0,0,0,0,0,0}};

    function automatic logic [63:0] root_part(input int c, input int d);
        logic [63:0] den;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] res;
        logic [63:0] bit_v;
        den   = 64'(d) * PI_Q30;
        r     = 64'(c);
        q     = '0;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 2 * ROOT_FRAC + 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v > q) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 0) begin
                if (q >= res + bit_v) begin
                    q   = q - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    function automatic t_as_tab build_as();
        t_as_tab tab;
        longint  v;
        for (int i = 0; i < N_TERMS; i++) begin
            v = longint'(T_A[i]) * longint'(root_part(T_C[i], T_D[i]));
            if (T_SG[i] < 0) begin
                v = -v;
            end
            tab[i] = AS_W'(v);
        end
        return tab;
    endfunction

    localparam t_as_tab AS_TAB = build_as();

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input logic [5:0] n);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (n - 6'd1));
        return t >>> n;
    endfunction

endpackage

>>> hdl/shbe_mul.sv
module shbe_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    import shbe_pkg::*;

    t_mul_ph     r_ph, n_ph;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] w_a32;
    logic [31:0] w_b32;
    logic [63:0] w_prod;

    assign w_a32  = (r_ph == PH_HL) ? r_a[63:32] : r_a[31:0];
    assign w_b32  = (r_ph == PH_LH) ? r_b[63:32] : r_b[31:0];
    assign w_prod = 64'(w_a32) * 64'(w_b32);

    always_comb begin
        case (r_ph)
            PH_LL: begin
                n_ph = PH_LH;
            end
            PH_LH: begin
                n_ph = PH_HL;
            end
            default: begin
                n_ph = PH_IDLE;
            end
        endcase
        if (i_start) begin
            n_ph = PH_LL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= (r_ph == PH_HL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_ph == PH_LL) begin
            r_acc <= w_prod;
        end else if (r_ph != PH_IDLE) begin
            r_acc <= r_acc + {w_prod[31:0], 32'd0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> hdl/spherical_harmonic_band_eval.sv
// Each product is formed on the shared 32x32 multiplier, one after another; terms with an
// x^2+y^2 part need one or two more products than the others.
// One request gives one band, taken only while idle; busy stays high until its last value.
// Values leave one per strobe cycle; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle and drops any request.
module spherical_harmonic_band_eval #(
    parameter int MAX_DEGREE = shbe_pkg::MAX_DEGREE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  shbe_pkg::t_req i_req,
    output logic           o_strobe,
    output shbe_pkg::t_res o_res
);
    import shbe_pkg::*;

    localparam int LW = $clog2(MAX_DEGREE + 2);

    t_state                    r_st,   n_st;
    logic                      r_wait, n_wait;
    logic signed [DIR_W-1:0]   r_x, r_y, r_z, n_x, n_y, n_z;
    logic [LW-1:0]             r_l, n_l, r_k, n_k;
    logic signed [ORDER_W-1:0] r_m, n_m;
    logic [3:0]                r_j, n_j;
    logic signed [63:0]        r_tmp, n_tmp, r_s30, n_s30, r_acc, n_acc, r_ext, n_ext;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic signed [63:0]        r_re [MAX_DEGREE+1];
    logic signed [63:0]        r_im [MAX_DEGREE+1];
    logic signed [63:0]        n_re [MAX_DEGREE+1];
    logic signed [63:0]        n_im [MAX_DEGREE+1];

    logic                      w_start, w_done, w_mul;
    logic [63:0]               w_a, w_b, w_p;
    logic signed [63:0]        w_prod, w_r, w_v, w_x, w_y, w_z;
    logic [LW-1:0]             w_am, w_km1;
    logic [IDX_W-1:0]          w_idx;
    logic signed [ORDER_W-1:0] w_ls;
    logic [DEG_W-1:0]          w_deg;

    function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [DIR_W-1:0] v);
        if (v > DIR_W'(UNIT_Q14)) begin
            return DIR_W'(UNIT_Q14);
        end else if (v < -DIR_W'(UNIT_Q14)) begin
            return -DIR_W'(UNIT_Q14);
        end
        return v;
    endfunction

    shbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_p     (w_p)
    );

    assign w_prod = signed'(w_p);
    assign w_x    = 64'(r_x);
    assign w_y    = 64'(r_y);
    assign w_z    = 64'(r_z);
    assign w_ls   = signed'(ORDER_W'(r_l));
    assign w_am   = r_m[ORDER_W-1] ? LW'(-r_m) : LW'(r_m);
    assign w_km1  = r_k - LW'(1);
    assign w_idx  = IDX_W'(T_BASE[r_l]) + IDX_W'(w_am);
    assign w_r    = r_m[ORDER_W-1] ? r_im[w_am] : r_re[w_am];
    assign w_deg  = (i_req.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : i_req.degree;
    assign w_v    = rnd(w_prod, 6'(28 + T_SH[w_idx]));

    assign busy     = (r_st != ST_IDLE);
    assign o_strobe = (r_st == ST_OUT);
    assign o_res    = '{order: r_m, value: r_val, last: (r_m == w_ls)};

    always_comb begin
        w_mul = 1'b1;
        w_a   = '0;
        w_b   = '0;
        case (r_st)
            ST_SQX: begin
                w_a = w_x;
                w_b = w_x;
            end
            ST_SQY: begin
                w_a = w_y;
                w_b = w_y;
            end
            ST_PW_RX: begin
                w_a = r_re[w_km1];
                w_b = w_x;
            end
            ST_PW_IY: begin
                w_a = r_im[w_km1];
                w_b = w_y;
            end
            ST_PW_RY: begin
                w_a = r_re[w_km1];
                w_b = w_y;
            end
            ST_PW_IX: begin
                w_a = r_im[w_km1];
                w_b = w_x;
            end
            ST_PH: begin
                w_a = r_acc;
                w_b = w_z;
            end
            ST_SC: begin
                w_a = 64'(T_SC[w_idx]);
                w_b = r_s30;
            end
            ST_SZ: begin
                w_a = r_ext;
                w_b = w_z;
            end
            ST_PR: begin
                w_a = rnd(r_acc, 6'd10);
                w_b = rnd(w_r, 6'd10);
            end
            ST_V: begin
                w_a = 64'(AS_TAB[w_idx]);
                w_b = r_tmp;
            end
            default: begin
                w_mul = 1'b0;
            end
        endcase
    end

    assign w_start = w_mul && !r_wait;

    always_comb begin
        n_st   = r_st;
        n_wait = r_wait;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_l    = r_l;
        n_k    = r_k;
        n_m    = r_m;
        n_j    = r_j;
        n_tmp  = r_tmp;
        n_s30  = r_s30;
        n_acc  = r_acc;
        n_ext  = r_ext;
        n_val  = r_val;
        n_re   = r_re;
        n_im   = r_im;
        if (w_start) begin
            n_wait = 1'b1;
        end
        if (w_done) begin
            n_wait = 1'b0;
        end
        case (r_st)
            ST_IDLE: begin
                if (start) begin
                    n_x     = sat_dir(i_req.dir_x);
                    n_y     = sat_dir(i_req.dir_y);
                    n_z     = sat_dir(i_req.dir_z);
                    n_l     = LW'(w_deg);
                    n_re[0] = 64'sd1 <<< 30;
                    n_im[0] = '0;
                    n_st    = ST_SQX;
                end
            end
            ST_SQX: begin
                if (w_done) begin
                    n_tmp = w_prod;
                    n_st  = ST_SQY;
                end
            end
            ST_SQY: begin
                if (w_done) begin
                    n_s30 = (r_tmp + w_prod) <<< 2;
                    n_k   = LW'(1);
                    n_m   = -w_ls;
                    n_acc = '0;
                    n_j   = 4'd9;
                    n_st  = (r_l == '0) ? ST_PH : ST_PW_RX;
                end
            end
            ST_PW_RX: begin
                if (w_done) begin
                    n_tmp = w_prod;
                    n_st  = ST_PW_IY;
                end
            end
            ST_PW_IY: begin
                if (w_done) begin
                    n_re[r_k] = rnd(r_tmp - w_prod, 6'd14);
                    n_st      = ST_PW_RY;
                end
            end
            ST_PW_RY: begin
                if (w_done) begin
                    n_tmp = w_prod;
                    n_st  = ST_PW_IX;
                end
            end
            ST_PW_IX: begin
                if (w_done) begin
                    n_im[r_k] = rnd(r_tmp + w_prod, 6'd14);
                    n_k       = r_k + LW'(1);
                    n_st      = (r_k == r_l) ? ST_PH : ST_PW_RX;
                end
            end
            ST_PH: begin
                if (w_done) begin
                    n_acc = rnd(w_prod, 6'd14) + (64'(T_P[w_idx][r_j]) <<< 30);
                    n_j   = r_j - 4'd1;
                    if (r_j == 4'd0) begin
                        n_st = (T_SC[w_idx] != 0) ? ST_SC : ST_PR;
                    end
                end
            end
            ST_SC: begin
                if (w_done) begin
                    n_ext = w_prod;
                    if (T_SZ[w_idx] != 0) begin
                        n_st = ST_SZ;
                    end else begin
                        n_acc = r_acc + w_prod;
                        n_st  = ST_PR;
                    end
                end
            end
            ST_SZ: begin
                if (w_done) begin
                    n_acc = r_acc + rnd(w_prod, 6'd14);
                    n_st  = ST_PR;
                end
            end
            ST_PR: begin
                if (w_done) begin
                    n_tmp = rnd(w_prod, 6'd20);
                    n_st  = ST_V;
                end
            end
            ST_V: begin
                if (w_done) begin
                    if (w_v > 64'sd32767) begin
                        n_val = 16'sh7FFF;
                    end else if (w_v < -64'sd32768) begin
                        n_val = 16'sh8000;
                    end else begin
                        n_val = w_v[VALUE_W-1:0];
                    end
                    n_st = ST_OUT;
                end
            end
            ST_OUT: begin
                n_acc = '0;
                n_j   = 4'd9;
                if (r_m == w_ls) begin
                    n_st = ST_IDLE;
                end else begin
                    n_m  = r_m + ORDER_W'(1);
                    n_st = ST_PH;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_wait <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_l   <= n_l;
        r_k   <= n_k;
        r_m   <= n_m;
        r_j   <= n_j;
        r_tmp <= n_tmp;
        r_s30 <= n_s30;
        r_acc <= n_acc;
        r_ext <= n_ext;
        r_val <= n_val;
        r_re  <= n_re;
        r_im  <= n_im;
    end

endmodule
